// ----- rtl/paid_pkg.sv -----
// Package for the positional array insert/delete block.
// Holds request kinds, status codes, widths and the result record type.
// No dependencies.
package paid_pkg;

    localparam int CAPACITY_DEFAULT = 64;

    localparam int KIND_W  = 2;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 7;
    localparam int IN_DW   = 40;   // position + value, padded to bytes
    localparam int OUT_DW  = 40;   // element + count_now, padded to bytes

    localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRAVERSE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  element;
        logic [CNT_W-1:0]  count_now;
        logic              last;
    } result_t;

endpackage

// ----- rtl/positional_array_insert_delete.sv -----
// Top level of the positional array insert/delete block.
// Uses paid_pkg and instantiates paid_out_buf.
//
// Usage
//   Requests arrive on the slave stream: tuser carries the kind (insert,
//   delete, traverse), tdata the position and the value. Results leave on
//   the master stream: tuser carries the status, tdata the element and the
//   count after the request, tlast marks the final result of a request.
//   One request is worked on at a time; s_axis_tready is high only while
//   the sequencer is idle. A request of unused kind is taken and dropped.
//   The list lives in a single synchronous RAM (one read, one write port,
//   registered read). An insert at position p with n entries moves n-p
//   entries at one per cycle, waits for the last move to land, then stores
//   the value and hands over the status; an append moves nothing. A delete
//   at p moves n-p-1 entries, none for the last entry. A traverse reads the
//   first entry, then gives one result per cycle while the receiver takes
//   them. Rejected requests only hand over their status.
//   Reset clears the count, so the list is empty; the RAM is not cleared.
//   A stalled receiver holds the result in the output register; the
//   sequencer waits, and the traverse read pipeline holds its data.
module positional_array_insert_delete
    import paid_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEFAULT   // 2 .. 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_DW-1:0]  s_axis_tdata,   // position[6:0], value[38:7], zero
    input  logic [KIND_W-1:0] s_axis_tuser,   // kind[1:0]
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata,   // element[31:0], count_now[38:32], zero
    output logic [STAT_W-1:0] m_axis_tuser,   // status[1:0]
    output logic              m_axis_tlast
);

    localparam int AW = $clog2(CAPACITY);

    // sequencer states
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_INS_SHIFT = 3'd1;
    localparam logic [2:0] S_INS_VAL   = 3'd2;
    localparam logic [2:0] S_DEL_SHIFT = 3'd3;
    localparam logic [2:0] S_DEL_DRAIN = 3'd4;
    localparam logic [2:0] S_TRAV      = 3'd5;
    localparam logic [2:0] S_RESP      = 3'd6;

    logic [2:0]        state_reg,  state_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [AW-1:0]     ptr_reg,    ptr_next;
    logic [STAT_W-1:0] stat_reg,   stat_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [AW-1:0]     pend_addr_reg,  pend_addr_next;
    logic [AW-1:0]     pos_reg;
    logic [VAL_W-1:0]  val_reg;

    // element RAM
    logic [VAL_W-1:0]  mem [CAPACITY];
    logic [VAL_W-1:0]  rd_data_reg;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              val_we;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [VAL_W-1:0]  mem_wdata;

    logic              in_accept;
    logic [KIND_W-1:0] in_kind;
    logic [POS_W-1:0]  in_pos;
    logic [VAL_W-1:0]  in_val;
    logic [AW-1:0]     last_idx;

    logic              emit;
    result_t           emit_res;
    logic              out_free;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_kind       = s_axis_tuser;
    assign in_pos        = s_axis_tdata[POS_W-1:0];
    assign in_val        = s_axis_tdata[POS_W+VAL_W-1:POS_W];
    assign last_idx      = AW'(count_reg - CNT_W'(1));

    // a pending shift write always wins the port; the inserted value
    // goes in only once the shift has drained
    assign mem_we    = pend_valid_reg || val_we;
    assign mem_waddr = pend_valid_reg ? pend_addr_reg : pos_reg;
    assign mem_wdata = pend_valid_reg ? rd_data_reg : val_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        stat_next       = stat_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        rd_en           = 1'b0;
        rd_addr         = ptr_reg;
        val_we          = 1'b0;
        emit            = 1'b0;
        emit_res        = '{status: stat_reg, element: '0, count_now: count_reg,
                            last: 1'b1};

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (in_kind)
                        KIND_INSERT:
                        begin
                            if (in_pos > count_reg)
                            begin
                                stat_next  = STAT_BADPOS;
                                state_next = S_RESP;
                            end
                            else if (count_reg == CNT_W'(CAPACITY))
                            begin
                                stat_next  = STAT_FULL;
                                state_next = S_RESP;
                            end
                            else if (in_pos == count_reg)
                            begin
                                state_next = S_INS_VAL;   // append, nothing to move
                            end
                            else
                            begin
                                ptr_next   = last_idx;
                                state_next = S_INS_SHIFT;
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (in_pos >= count_reg)
                            begin
                                stat_next  = STAT_BADPOS;
                                state_next = S_RESP;
                            end
                            else if (in_pos == count_reg - CNT_W'(1))
                            begin
                                count_next = count_reg - CNT_W'(1);
                                stat_next  = STAT_OK;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                ptr_next   = in_pos[AW-1:0] + AW'(1);
                                state_next = S_DEL_SHIFT;
                            end
                        end
                        KIND_TRAVERSE:
                        begin
                            if (count_reg == '0)
                            begin
                                stat_next  = STAT_EMPTY;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                ptr_next   = '0;
                                state_next = S_TRAV;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_INS_SHIFT:
            begin
                // read entry ptr, write it one place up next cycle
                rd_en           = 1'b1;
                rd_addr         = ptr_reg;
                pend_valid_next = 1'b1;
                pend_addr_next  = ptr_reg + AW'(1);
                if (ptr_reg == pos_reg)
                begin
                    state_next = S_INS_VAL;
                end
                else
                begin
                    ptr_next = ptr_reg - AW'(1);
                end
            end

            S_INS_VAL:
            begin
                if (!pend_valid_reg)
                begin
                    val_we     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    stat_next  = STAT_OK;
                    state_next = S_RESP;
                end
            end

            S_DEL_SHIFT:
            begin
                // read entry ptr, write it one place down next cycle
                rd_en           = 1'b1;
                rd_addr         = ptr_reg;
                pend_valid_next = 1'b1;
                pend_addr_next  = ptr_reg - AW'(1);
                if (ptr_reg == last_idx)
                begin
                    state_next = S_DEL_DRAIN;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end

            S_DEL_DRAIN:
            begin
                // final shift write lands this cycle
                count_next = count_reg - CNT_W'(1);
                stat_next  = STAT_OK;
                state_next = S_RESP;
            end

            S_TRAV:
            begin
                emit     = 1'b1;
                emit_res = '{status: STAT_OK, element: rd_data_reg,
                             count_now: count_reg, last: (ptr_reg == last_idx)};
                if (out_free)
                begin
                    if (ptr_reg == last_idx)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        rd_addr  = ptr_reg + AW'(1);
                        ptr_next = ptr_reg + AW'(1);
                    end
                end
            end

            S_RESP:
            begin
                emit = 1'b1;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            ptr_reg        <= '0;
            stat_reg       <= STAT_OK;
            pend_valid_reg <= 1'b0;
            pend_addr_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            ptr_reg        <= ptr_next;
            stat_reg       <= stat_next;
            pend_valid_reg <= pend_valid_next;
            pend_addr_reg  <= pend_addr_next;
        end
    end

    // request payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pos_reg <= in_pos[AW-1:0];
            val_reg <= in_val;
        end
    end

    // RAM: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    paid_out_buf u_out_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (emit),
        .res_in        (emit_res),
        .free          (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_no_pend_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !pend_valid_reg)
        else $error("shift write still pending while taking a request");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CNT_W'(1)) ||
            (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("count moved by more than one");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == STAT_EMPTY) |->
            (m_axis_tlast && m_axis_tdata[VAL_W+CNT_W-1:VAL_W] == '0))
        else $error("empty-list result with nonzero count or no tlast");
`endif

endmodule

// ----- rtl/paid_out_buf.sv -----
// Output register stage for the positional array block.
// Holds one result and drives the master stream; depends on paid_pkg.
module paid_out_buf
    import paid_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,       // take res_in this cycle if free is high
    input  result_t           res_in,
    output logic              free,       // a load would be taken this cycle
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata,  // element[31:0], count_now[38:32], zero
    output logic [STAT_W-1:0] m_axis_tuser,  // status[1:0]
    output logic              m_axis_tlast
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free = !valid_reg || m_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            res_reg <= res_in;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {{(OUT_DW - VAL_W - CNT_W){1'b0}}, res_reg.count_now,
                            res_reg.element};
    assign m_axis_tuser  = res_reg.status;
    assign m_axis_tlast  = res_reg.last;

endmodule

// ----- sim/tb_positional_array_insert_delete.sv -----
// Testbench for positional_array_insert_delete: self-checking stream test.
// Depends on rtl/paid_pkg.sv and rtl/positional_array_insert_delete.sv.
// Holds its own list model, a queued request driver and a result monitor.
`timescale 1ns / 1ps

module tb_positional_array_insert_delete;
    import paid_pkg::*;

    localparam int LIST_CAP       = CAPACITY_DEFAULT;
    localparam int HOLD_CYCLES    = 300;    // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no handshake at all
    localparam int DRAIN_CYCLES   = LIST_CAP + 10;

    // Kind 3 is not an operation; the block takes it and drops it.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  position;
        logic [VAL_W-1:0]  value;
    } request_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_DW-1:0]  s_axis_tdata = '0;    // position[6:0], value[38:7], zero
    logic [KIND_W-1:0] s_axis_tuser = '0;    // kind[1:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_DW-1:0] m_axis_tdata;         // element[31:0], count_now[38:32], zero
    logic [STAT_W-1:0] m_axis_tuser;         // status[1:0]
    logic              m_axis_tlast;

    // Requests waiting to be offered, and results the list model predicts.
    request_t pending_requests[$];
    result_t  expected_results[$];
    request_t req_on_bus;

    // List model: packed entries and their count.
    logic [VAL_W-1:0] list_mem [0:LIST_CAP-1];
    int               list_len;

    // Count as the generator sees it, so positions can be aimed in range.
    int plan_len;

    // Idling controls for the current phase, in percent.
    int send_idle_pct;
    int stall_pct;

    // Hold-off handshake between the stimulus process and the receiver.
    int hold_requests;
    int holds_done;
    int hold_left;

    int mismatches;
    int quiet_cycles;

    positional_array_insert_delete #(.CAPACITY(LIST_CAP)) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Apply one accepted request to the list model and queue its results.
    task automatic predict_request(input request_t req);
        logic [STAT_W-1:0] st;
        int                i;
        begin
            st = STAT_OK;
            case (req.kind)
                KIND_INSERT:
                begin
                    if (int'(req.position) > list_len)
                        st = STAT_BADPOS;
                    else if (list_len >= LIST_CAP)
                        st = STAT_FULL;
                    else
                    begin
                        for (i = list_len; i > int'(req.position); i--)
                            list_mem[i] = list_mem[i-1];
                        list_mem[req.position] = req.value;
                        list_len++;
                    end
                    expected_results.push_back('{st, '0, CNT_W'(list_len), 1'b1});
                end
                KIND_DELETE:
                begin
                    if (int'(req.position) >= list_len)
                        st = STAT_BADPOS;
                    else
                    begin
                        for (i = int'(req.position); i + 1 < list_len; i++)
                            list_mem[i] = list_mem[i+1];
                        list_len--;
                    end
                    expected_results.push_back('{st, '0, CNT_W'(list_len), 1'b1});
                end
                KIND_TRAVERSE:
                begin
                    if (list_len == 0)
                        expected_results.push_back('{STAT_EMPTY, '0, '0, 1'b1});
                    else
                        for (i = 0; i < list_len; i++)
                            expected_results.push_back('{STAT_OK, list_mem[i],
                                CNT_W'(list_len), (i + 1 == list_len)});
                end
                default: ;  // unused kind: no result, no change
            endcase
        end
    endtask

    // Queue a request and track the count it leaves behind.
    task automatic queue_request(input logic [KIND_W-1:0] kind, input int pos,
                                 input logic [VAL_W-1:0] val);
        begin
            pending_requests.push_back('{kind, POS_W'(pos), val});
            if (kind == KIND_INSERT && pos <= plan_len && plan_len < LIST_CAP)
                plan_len++;
            else if (kind == KIND_DELETE && pos < plan_len)
                plan_len--;
        end
    endtask

    // Random requests: mostly in-range inserts/deletes that swing the list
    // between nearly empty and full, with traverses, bad positions and the
    // odd dropped kind mixed in. The trend state lives across calls.
    bit growing = 1'b1;

    task automatic random_requests(input int n);
        int               k;
        int               r;
        int               pos;
        logic [VAL_W-1:0] val;
        bit               bad;
        begin
            for (k = 0; k < n; k++)
            begin
                r = $urandom_range(0, 99);
                case ($urandom_range(0, 15))
                    0:       val = 32'h7FFF_FFFF;
                    1:       val = 32'h8000_0000;
                    default: val = $urandom;
                endcase
                bad = ($urandom_range(0, 99) < 10);
                if (r < 7)
                    queue_request(KIND_TRAVERSE, $urandom_range(0, LIST_CAP), val);
                else if (r < 8)
                    queue_request(KIND_UNUSED, $urandom_range(0, LIST_CAP), val);
                else if (growing ? (r < 90) : (r < 30))
                begin
                    if (bad && plan_len < LIST_CAP)
                        pos = $urandom_range(plan_len + 1, LIST_CAP);
                    else
                        pos = $urandom_range(0, plan_len);   // full list: store full
                    queue_request(KIND_INSERT, pos, val);
                end
                else
                begin
                    if (bad || plan_len == 0)
                        pos = $urandom_range(plan_len, LIST_CAP);
                    else
                        pos = $urandom_range(0, plan_len - 1);
                    queue_request(KIND_DELETE, pos, val);
                end
                if (growing && plan_len == LIST_CAP && $urandom_range(0, 3) == 0)
                    growing = 1'b0;
                else if (!growing && plan_len <= 2)
                    growing = 1'b1;
            end
        end
    endtask

    // Wait until every queued request is taken and every result is back.
    task automatic settle();
        begin
            while (pending_requests.size() != 0 || s_axis_tvalid ||
                   expected_results.size() != 0)
                @(posedge clk);
        end
    endtask

    // Driver: offers queued requests, holding each until the block takes it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_request(req_on_bus);
            if (s_axis_tvalid && !s_axis_tready)
                ;   // keep offering the same request
            else if (pending_requests.size() != 0 &&
                     $urandom_range(0, 99) >= send_idle_pct)
            begin
                req_on_bus = pending_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {1'b0, req_on_bus.value, req_on_bus.position};
                s_axis_tuser  <= req_on_bus.kind;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Monitor and receiver: checks each result against the oldest
    // prediction, then decides tready for the next cycle.
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{m_axis_tuser, m_axis_tdata[VAL_W-1:0],
                        m_axis_tdata[VAL_W +: CNT_W], m_axis_tlast};
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result status=%0d element=%0d count=%0d last=%0d",
                             $realtime, got.status, $signed(got.element),
                             got.count_now, got.last);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        $display("%0t: expected status=%0d element=%0d count=%0d last=%0d",
                                 $realtime, want.status, $signed(want.element),
                                 want.count_now, want.last);
                        $display("%0t:   actual status=%0d element=%0d count=%0d last=%0d",
                                 $realtime, got.status, $signed(got.element),
                                 got.count_now, got.last);
                    end
                end
            end

            if (holds_done != hold_requests)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Watchdog: ends the run if neither side moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        list_len      = 0;
        plan_len      = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_requests = 0;
        holds_done    = 0;
        mismatches    = 0;
        quiet_cycles  = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling: empty list, ends, middle, bad positions,
        // dropped kind and the return to empty.
        queue_request(KIND_TRAVERSE, 0, '0);            // traverse of empty list
        queue_request(KIND_DELETE, 0, '0);              // delete on empty list
        queue_request(KIND_INSERT, 1, 32'h1234_5678);   // insert past the end
        queue_request(KIND_INSERT, 0, 32'h7FFF_FFFF);
        queue_request(KIND_INSERT, 0, 32'h8000_0000);   // front
        queue_request(KIND_INSERT, 2, 32'h0000_0000);   // end
        queue_request(KIND_INSERT, 1, 32'hFFFF_FFFF);   // middle
        queue_request(KIND_TRAVERSE, 64, '1);
        queue_request(KIND_INSERT, 64, 32'hDEAD_BEEF);  // far past the end
        queue_request(KIND_DELETE, 4, '0);              // at the count
        queue_request(KIND_DELETE, 63, '0);
        queue_request(KIND_UNUSED, 0, 32'hCAFE_F00D);   // dropped
        queue_request(KIND_DELETE, 0, '0);              // front
        queue_request(KIND_DELETE, 2, '0);              // last entry
        queue_request(KIND_DELETE, 0, '0);
        queue_request(KIND_TRAVERSE, 0, '0);
        queue_request(KIND_INSERT, 1, 32'h5555_5555);
        queue_request(KIND_INSERT, 0, 32'hAAAA_AAAA);
        queue_request(KIND_TRAVERSE, 0, '0);
        queue_request(KIND_DELETE, 1, '0);
        queue_request(KIND_DELETE, 0, '0);
        queue_request(KIND_DELETE, 1, '0);
        queue_request(KIND_DELETE, 0, '0);              // now empty again
        queue_request(KIND_TRAVERSE, 0, '0);

        // Receiver holds off while requests keep coming, so the block
        // backs up and drops s_axis_tready.
        hold_requests++;
        random_requests(55);
        settle();

        send_idle_pct = 64;
        stall_pct     = 0;
        random_requests(55);
        settle();

        send_idle_pct = 0;
        stall_pct     = 64;
        random_requests(55);
        settle();

        send_idle_pct = 20;
        stall_pct     = 20;
        random_requests(55);
        settle();

        // Let a trailing dropped request run out before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
